// File: hw/rtl/gvf_pkg.sv
// shared types, constants and sizes of the garch variance filter
package gvf_pkg;

  localparam int MAX_ARCH_LAGS  = 8;
  localparam int MAX_GARCH_LAGS = 8;
  localparam int MAX_REGRESSORS = 4;

  // the ports always carry four regressors
  localparam int NUM_REG_PORTS = 4;
  localparam int REG_SEL_W     = $clog2(NUM_REG_PORTS);

  // coefficient table: betas, then arch weights, then garch weights
  localparam int TABLE_DEPTH = MAX_REGRESSORS + MAX_ARCH_LAGS + MAX_GARCH_LAGS;
  localparam int ARCH_BASE   = MAX_REGRESSORS;
  localparam int GARCH_BASE  = MAX_REGRESSORS + MAX_ARCH_LAGS;
  localparam int COEF_AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // residual and variance histories share one ring buffer
  localparam int HIST_DEPTH = (MAX_ARCH_LAGS > MAX_GARCH_LAGS) ? MAX_ARCH_LAGS
                                                               : MAX_GARCH_LAGS;
  localparam int HIST_AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int FILL_W     = $clog2(HIST_DEPTH + 1);

  localparam int DATA_W   = 32;
  localparam int ACC_W    = 64;
  localparam int FRAC_W   = 16;
  localparam int CFG_IDX_W = 3;

  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_WRITE  = 1'b1
  } req_type_t;

  typedef enum logic [1:0] {
    KIND_BETA  = 2'd0,
    KIND_ARCH  = 2'd1,
    KIND_GARCH = 2'd2
  } coef_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CONST_ENABLE    = 3'd0,
    CFG_CONST_TERM      = 3'd1,
    CFG_REGRESSOR_COUNT = 3'd2,
    CFG_ARCH_LAGS       = 3'd3,
    CFG_GARCH_LAGS      = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    TERM_BETA  = 2'd0,
    TERM_ARCH  = 2'd1,
    TERM_GARCH = 2'd2
  } term_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  // control that travels with each term through the mac pipeline
  typedef struct packed {
    logic       valid;
    logic       en;
    term_kind_t kind;
    logic       last;
  } term_ctl_t;

endpackage

// File: hw/rtl/garch_variance_filter_top.sv
// garch(p,q) conditional variance filter: sequencer, memories and mac pipeline
// a sample request is taken only while idle; its 20 coefficient slots are then
// walked one per cycle through the coefficient ram, followed by read, square,
// multiply and accumulate; no new sample is taken until that variance is pushed
// a coefficient write gives no result
// reset: registers to their defaults, histories empty, coefficients read as zero
module garch_variance_filter_top (
  input  logic                                clk,
  input  logic                                rst,
  // request channel
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic                                req_type,
  input  logic [1:0]                          coef_kind,
  input  logic [2:0]                          coef_index,
  input  logic signed [gvf_pkg::DATA_W-1:0]   coef_value,
  input  logic                                first_of_series,
  input  logic signed [gvf_pkg::DATA_W-1:0]   residual,
  input  logic signed [gvf_pkg::DATA_W-1:0]   regressor_0,
  input  logic signed [gvf_pkg::DATA_W-1:0]   regressor_1,
  input  logic signed [gvf_pkg::DATA_W-1:0]   regressor_2,
  input  logic signed [gvf_pkg::DATA_W-1:0]   regressor_3,
  // result channel
  output logic                                var_valid,
  input  logic                                var_stall,
  output logic signed [gvf_pkg::DATA_W-1:0]   variance,
  // configuration port
  input  logic                                cfg_write,
  input  logic [gvf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gvf_pkg::DATA_W-1:0]          cfg_data
);

  localparam logic signed [gvf_pkg::ACC_W-1:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [gvf_pkg::ACC_W-1:0] SAT_MIN = -64'sd2147483648;

  // configuration registers
  logic                               const_enable;
  logic signed [gvf_pkg::DATA_W-1:0]  const_term;
  logic [2:0]                         regressor_count;
  logic [3:0]                         arch_lags;
  logic [3:0]                         garch_lags;

  // sequencer
  gvf_pkg::state_t                    state;
  gvf_pkg::state_t                    state_next;
  logic [gvf_pkg::COEF_AW-1:0]        term;
  logic                               req_acc;
  logic                               var_acc;
  logic                               start;
  logic                               issue;
  logic                               push;

  // captured sample
  logic signed [gvf_pkg::DATA_W-1:0]  res_cap;
  logic signed [gvf_pkg::DATA_W-1:0]  regs [gvf_pkg::NUM_REG_PORTS];

  // history ring: head is the next slot written, fill counts live entries
  logic [gvf_pkg::HIST_AW-1:0]        head;
  logic [gvf_pkg::FILL_W-1:0]         fill;

  // coefficient entries never written read as zero
  logic [gvf_pkg::TABLE_DEPTH-1:0]    coef_written;

  // coefficient ram ports
  logic                               coef_we;
  logic [gvf_pkg::COEF_AW-1:0]        coef_waddr;
  logic [gvf_pkg::DATA_W-1:0]         coef_rdata;

  // history ram ports, word is {residual, variance}
  logic [gvf_pkg::HIST_AW-1:0]        hist_raddr;
  logic [2*gvf_pkg::DATA_W-1:0]       hist_rdata;

  // term decode in the issue cycle
  gvf_pkg::term_kind_t                t_kind;
  logic [gvf_pkg::HIST_AW-1:0]        t_lag;
  logic                               t_en;
  logic [gvf_pkg::HIST_AW:0]          slot_sum;

  // stage after the ram read
  gvf_pkg::term_ctl_t                 s0_ctl;
  logic                               s0_lag_ok;
  logic                               s0_coef_ok;
  logic signed [gvf_pkg::DATA_W-1:0]  s0_reg;
  logic signed [gvf_pkg::DATA_W-1:0]  mac_coef;
  logic signed [gvf_pkg::DATA_W-1:0]  mac_x;

  logic signed [gvf_pkg::ACC_W-1:0]   acc_init;
  logic signed [gvf_pkg::ACC_W-1:0]   acc;
  logic                               acc_ready;
  logic signed [gvf_pkg::DATA_W-1:0]  var_sat;

  assign req_acc = req_valid && !req_stall;
  assign var_acc = var_valid && !var_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      const_enable    <= 1'b0;
      const_term      <= '0;
      regressor_count <= '0;
      arch_lags       <= 4'd1;
      garch_lags      <= 4'd1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        gvf_pkg::CFG_CONST_ENABLE:    const_enable    <= cfg_data[0];
        gvf_pkg::CFG_CONST_TERM:      const_term      <= cfg_data;
        gvf_pkg::CFG_REGRESSOR_COUNT: regressor_count <= cfg_data[2:0];
        gvf_pkg::CFG_ARCH_LAGS:       arch_lags       <= cfg_data[3:0];
        gvf_pkg::CFG_GARCH_LAGS:      garch_lags      <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // coefficient write decode, out-of-range indices are dropped
  always_comb begin
    coef_we    = 1'b0;
    coef_waddr = '0;
    if (req_acc && (req_type == gvf_pkg::REQ_WRITE)) begin
      unique case (coef_kind)
        gvf_pkg::KIND_BETA: begin
          coef_we    = (32'(coef_index) < gvf_pkg::MAX_REGRESSORS);
          coef_waddr = gvf_pkg::COEF_AW'(coef_index);
        end
        gvf_pkg::KIND_ARCH: begin
          coef_we    = (32'(coef_index) < gvf_pkg::MAX_ARCH_LAGS);
          coef_waddr = gvf_pkg::COEF_AW'(gvf_pkg::ARCH_BASE)
                     + gvf_pkg::COEF_AW'(coef_index);
        end
        gvf_pkg::KIND_GARCH: begin
          coef_we    = (32'(coef_index) < gvf_pkg::MAX_GARCH_LAGS);
          coef_waddr = gvf_pkg::COEF_AW'(gvf_pkg::GARCH_BASE)
                     + gvf_pkg::COEF_AW'(coef_index);
        end
        default: ;
      endcase
    end
  end

  // sequencer: walk every table slot, then wait for the accumulator and a free result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gvf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_stall  = 1'b1;
    start      = 1'b0;
    issue      = 1'b0;
    push       = 1'b0;
    unique case (state)
      gvf_pkg::ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid && (req_type == gvf_pkg::REQ_SAMPLE)) begin
          start      = 1'b1;
          state_next = gvf_pkg::ST_RUN;
        end
      end
      gvf_pkg::ST_RUN: begin
        issue = 1'b1;
        if (32'(term) == gvf_pkg::TABLE_DEPTH - 1) begin
          state_next = gvf_pkg::ST_DRAIN;
        end
      end
      gvf_pkg::ST_DRAIN: begin
        // result register must be free or emptying this cycle
        if (acc_ready && (!var_valid || !var_stall)) begin
          push       = 1'b1;
          state_next = gvf_pkg::ST_IDLE;
        end
      end
      default: state_next = gvf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (start) begin
      term <= '0;
    end else if (issue) begin
      term <= term + 1'b1;
    end
  end

  // sample capture
  always_ff @(posedge clk) begin
    if (start) begin
      res_cap <= residual;
      regs[0] <= regressor_0;
      regs[1] <= regressor_1;
      regs[2] <= regressor_2;
      regs[3] <= regressor_3;
    end
  end

  // history bookkeeping: first_of_series empties the ring before the sample
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      fill <= '0;
    end else if (start && first_of_series) begin
      fill <= '0;
    end else if (push) begin
      head <= (32'(head) == gvf_pkg::HIST_DEPTH - 1) ? '0 : head + 1'b1;
      if (32'(fill) != gvf_pkg::HIST_DEPTH) begin
        fill <= fill + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_written <= '0;
    end else if (coef_we) begin
      coef_written[coef_waddr] <= 1'b1;
    end
  end

  // term decode: slot index gives group and lag
  always_comb begin
    if (32'(term) < gvf_pkg::ARCH_BASE) begin
      t_kind = gvf_pkg::TERM_BETA;
      t_lag  = '0;
      t_en   = (32'(term) < 32'(regressor_count));
    end else if (32'(term) < gvf_pkg::GARCH_BASE) begin
      t_kind = gvf_pkg::TERM_ARCH;
      t_lag  = gvf_pkg::HIST_AW'(term - gvf_pkg::COEF_AW'(gvf_pkg::ARCH_BASE));
      t_en   = (32'(t_lag) < 32'(arch_lags));
    end else begin
      t_kind = gvf_pkg::TERM_GARCH;
      t_lag  = gvf_pkg::HIST_AW'(term - gvf_pkg::COEF_AW'(gvf_pkg::GARCH_BASE));
      t_en   = (32'(t_lag) < 32'(garch_lags));
    end
    // lag l lives at head - 1 - l, wrapped around the ring
    slot_sum = (gvf_pkg::HIST_AW+1)'(head)
             + (gvf_pkg::HIST_AW+1)'(gvf_pkg::HIST_DEPTH - 1)
             - (gvf_pkg::HIST_AW+1)'(t_lag);
    if (32'(slot_sum) >= gvf_pkg::HIST_DEPTH) begin
      hist_raddr = gvf_pkg::HIST_AW'(slot_sum - (gvf_pkg::HIST_AW+1)'(gvf_pkg::HIST_DEPTH));
    end else begin
      hist_raddr = gvf_pkg::HIST_AW'(slot_sum);
    end
  end

  // control and side data that line up with the ram read data
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_ctl <= '0;
    end else begin
      s0_ctl.valid <= issue;
      s0_ctl.en    <= t_en;
      s0_ctl.kind  <= t_kind;
      s0_ctl.last  <= (32'(term) == gvf_pkg::TABLE_DEPTH - 1);
    end
  end

  always_ff @(posedge clk) begin
    s0_lag_ok  <= (32'(t_lag) < 32'(fill));
    s0_coef_ok <= coef_written[term];
    s0_reg     <= regs[term[gvf_pkg::REG_SEL_W-1:0]];
  end

  // operands: empty history slots and unwritten coefficients count as zero
  always_comb begin
    mac_coef = s0_coef_ok ? coef_rdata : '0;
    case (s0_ctl.kind)
      gvf_pkg::TERM_BETA:  mac_x = s0_reg;
      gvf_pkg::TERM_ARCH:  mac_x = s0_lag_ok
                                 ? hist_rdata[2*gvf_pkg::DATA_W-1:gvf_pkg::DATA_W] : '0;
      gvf_pkg::TERM_GARCH: mac_x = s0_lag_ok ? hist_rdata[gvf_pkg::DATA_W-1:0] : '0;
      default:             mac_x = '0;
    endcase
  end

  assign acc_init = const_enable ? gvf_pkg::ACC_W'(const_term) : '0;

  gvf_ram #(
    .WIDTH (gvf_pkg::DATA_W),
    .DEPTH (gvf_pkg::TABLE_DEPTH)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (coef_value),
    .raddr (term),
    .rdata (coef_rdata)
  );

  gvf_ram #(
    .WIDTH (2*gvf_pkg::DATA_W),
    .DEPTH (gvf_pkg::HIST_DEPTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (push),
    .waddr (head),
    .wdata ({res_cap, var_sat}),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  gvf_mac u_mac (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .init  (acc_init),
    .ctl   (s0_ctl),
    .coef  (mac_coef),
    .x     (mac_x),
    .acc   (acc),
    .ready (acc_ready)
  );

  // saturate the 64-bit sum to the signed 32-bit range
  always_comb begin
    if (acc > SAT_MAX) begin
      var_sat = {1'b0, {(gvf_pkg::DATA_W-1){1'b1}}};
    end else if (acc < SAT_MIN) begin
      var_sat = {1'b1, {(gvf_pkg::DATA_W-1){1'b0}}};
    end else begin
      var_sat = acc[gvf_pkg::DATA_W-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      var_valid <= 1'b0;
    end else if (push) begin
      var_valid <= 1'b1;
    end else if (var_acc) begin
      var_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      variance <= var_sat;
    end
  end

endmodule

// File: hw/rtl/gvf_ram.sv
// generic single-port-write, single-port-read ram with registered read
module gvf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/gvf_mac.sv
// term pipeline: residual squaring, coefficient multiply and 64-bit accumulate
module gvf_mac (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic signed [gvf_pkg::ACC_W-1:0]  init,
  input  gvf_pkg::term_ctl_t              ctl,
  input  logic signed [gvf_pkg::DATA_W-1:0] coef,
  input  logic signed [gvf_pkg::DATA_W-1:0] x,
  output logic signed [gvf_pkg::ACC_W-1:0]  acc,
  output logic                            ready
);

  // stage a: square of the operand, used by arch terms
  gvf_pkg::term_ctl_t                a_ctl;
  logic signed [gvf_pkg::DATA_W-1:0] a_coef;
  logic signed [gvf_pkg::DATA_W-1:0] a_x;
  logic signed [gvf_pkg::ACC_W-1:0]  a_sq;

  // stage b: coefficient product
  gvf_pkg::term_ctl_t                b_ctl;
  logic signed [gvf_pkg::ACC_W-1:0]  b_prod;

  logic [gvf_pkg::ACC_W-gvf_pkg::FRAC_W-1:0] sq_shift;
  logic signed [gvf_pkg::DATA_W-1:0]         sq_sat;
  logic signed [gvf_pkg::DATA_W-1:0]         b_op;

  // square floored to q16.16, saturated to the positive range
  always_comb begin
    sq_shift = a_sq[gvf_pkg::ACC_W-1:gvf_pkg::FRAC_W];
    if (|sq_shift[gvf_pkg::ACC_W-gvf_pkg::FRAC_W-1:gvf_pkg::DATA_W-1]) begin
      sq_sat = {1'b0, {(gvf_pkg::DATA_W-1){1'b1}}};
    end else begin
      sq_sat = {1'b0, sq_shift[gvf_pkg::DATA_W-2:0]};
    end
    b_op = (a_ctl.kind == gvf_pkg::TERM_ARCH) ? sq_sat : a_x;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_ctl <= '0;
      b_ctl <= '0;
      ready <= 1'b0;
    end else begin
      a_ctl <= ctl;
      b_ctl <= a_ctl;
      if (start) begin
        ready <= 1'b0;
      end else if (b_ctl.valid && b_ctl.last) begin
        ready <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_coef <= coef;
    a_x    <= x;
    a_sq   <= gvf_pkg::ACC_W'(x) * gvf_pkg::ACC_W'(x);
    b_prod <= gvf_pkg::ACC_W'(a_coef) * gvf_pkg::ACC_W'(b_op);
    if (start) begin
      acc <= init;
    end else if (b_ctl.valid && b_ctl.en) begin
      acc <= acc + (b_prod >>> gvf_pkg::FRAC_W);
    end
  end

endmodule

// File: tb/sv/tb_garch_variance_filter_top.sv
// self-checking testbench for the garch variance filter: directed and random requests
`timescale 1ns / 100ps

module tb_garch_variance_filter_top;

  // run sizing
  localparam int RANDOM_ITEMS  = 1750;
  localparam int PHASE_ITEMS   = 250;
  // covers a request still in flight while no result is pending (coefficient writes)
  localparam int SETTLE_CYCLES = 32;
  // cycles with no request or result accepted before the run is called hung
  localparam int IDLE_LIMIT    = 2000;
  localparam int REPORT_LIMIT  = 10;

  // saturation bounds: the signed 32-bit range the 64-bit sum is clipped to
  localparam longint VAR_MAX = 64'sd2147483647;
  localparam longint VAR_MIN = -64'sd2147483648;

  // q16.16 corner values
  localparam logic [gvf_pkg::DATA_W-1:0] Q_MAX  = 32'h7fff_ffff;
  localparam logic [gvf_pkg::DATA_W-1:0] Q_MIN  = 32'h8000_0000;
  localparam logic [gvf_pkg::DATA_W-1:0] Q_ONE  = 32'h0001_0000;
  localparam logic [gvf_pkg::DATA_W-1:0] Q_HALF = 32'h0000_8000;
  localparam logic [gvf_pkg::DATA_W-1:0] Q_ZERO = 32'h0000_0000;

  // coefficient group code that the block has no table for
  localparam logic [1:0] KIND_NONE = 2'd3;

  // one request as it sits on the input ports
  typedef struct packed {
    gvf_pkg::req_type_t                                     rtype;
    logic [1:0]                                             kind;
    logic [2:0]                                             index;
    logic [gvf_pkg::DATA_W-1:0]                             coef;
    logic                                                   first;
    logic [gvf_pkg::DATA_W-1:0]                             resid;
    logic [gvf_pkg::NUM_REG_PORTS-1:0][gvf_pkg::DATA_W-1:0] regr;
  } gvf_request_t;

  // clock, reset and block ports; the driven ones are known from time zero
  logic                          clk             = 1'b0;
  logic                          rst             = 1'b1;
  logic                          req_valid       = 1'b0;
  logic                          req_stall;
  logic                          req_type        = 1'b0;
  logic [1:0]                    coef_kind       = '0;
  logic [2:0]                    coef_index      = '0;
  logic [gvf_pkg::DATA_W-1:0]    coef_value      = '0;
  logic                          first_of_series = 1'b0;
  logic [gvf_pkg::DATA_W-1:0]    residual        = '0;
  logic [gvf_pkg::DATA_W-1:0]    regressor_0     = '0;
  logic [gvf_pkg::DATA_W-1:0]    regressor_1     = '0;
  logic [gvf_pkg::DATA_W-1:0]    regressor_2     = '0;
  logic [gvf_pkg::DATA_W-1:0]    regressor_3     = '0;
  logic                          var_valid;
  logic                          var_stall       = 1'b0;
  logic [gvf_pkg::DATA_W-1:0]    variance;
  logic                          cfg_write       = 1'b0;
  logic [gvf_pkg::CFG_IDX_W-1:0] cfg_index       = '0;
  logic [gvf_pkg::DATA_W-1:0]    cfg_data        = '0;

  // predicted filter state: delay lines, coefficient table and registers
  logic signed [gvf_pkg::DATA_W-1:0] resid_line   [gvf_pkg::MAX_ARCH_LAGS];
  logic signed [gvf_pkg::DATA_W-1:0] var_line     [gvf_pkg::MAX_GARCH_LAGS];
  logic signed [gvf_pkg::DATA_W-1:0] weight_table [gvf_pkg::TABLE_DEPTH];
  logic                              m_const_en;
  logic signed [gvf_pkg::DATA_W-1:0] m_const_term;
  logic [2:0]                        m_regressors;
  logic [3:0]                        m_arch_lags;
  logic [3:0]                        m_garch_lags;

  // variances still owed by the block, oldest first
  logic [gvf_pkg::DATA_W-1:0] expected_variances [$];
  logic [gvf_pkg::DATA_W-1:0] want_variance;
  int                         mismatch_count = 0;

  // idling control: steady turns off gaps on both sides for a stretch
  bit steady     = 1'b0;
  int stall_hold = 0;

  garch_variance_filter_top DUT (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req_valid),
    .req_stall       (req_stall),
    .req_type        (req_type),
    .coef_kind       (coef_kind),
    .coef_index      (coef_index),
    .coef_value      (coef_value),
    .first_of_series (first_of_series),
    .residual        (residual),
    .regressor_0     (regressor_0),
    .regressor_1     (regressor_1),
    .regressor_2     (regressor_2),
    .regressor_3     (regressor_3),
    .var_valid       (var_valid),
    .var_stall       (var_stall),
    .variance        (variance),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // mirror of one register write; unknown indexes change nothing
  task automatic note_register(input logic [gvf_pkg::CFG_IDX_W-1:0] idx,
                               input logic [gvf_pkg::DATA_W-1:0] data);
    case (idx)
      gvf_pkg::CFG_CONST_ENABLE:    m_const_en   = data[0];
      gvf_pkg::CFG_CONST_TERM:      m_const_term = data;
      gvf_pkg::CFG_REGRESSOR_COUNT: m_regressors = data[2:0];
      gvf_pkg::CFG_ARCH_LAGS:       m_arch_lags  = data[3:0];
      gvf_pkg::CFG_GARCH_LAGS:      m_garch_lags = data[3:0];
      default: ;
    endcase
  endtask

  // applies one accepted request to the predicted state; a sample also queues its variance
  task automatic predict_variance_step(input gvf_request_t rq);
    longint acc, prod, sq;
    int     nb, np, nq;
    // coefficient write: stored only if the index fits its group, no result
    if (rq.rtype == gvf_pkg::REQ_WRITE) begin
      case (rq.kind)
        gvf_pkg::KIND_BETA: begin
          if (rq.index < gvf_pkg::MAX_REGRESSORS) weight_table[rq.index] = rq.coef;
        end
        gvf_pkg::KIND_ARCH: begin
          if (rq.index < gvf_pkg::MAX_ARCH_LAGS)
            weight_table[gvf_pkg::ARCH_BASE + rq.index] = rq.coef;
        end
        gvf_pkg::KIND_GARCH: begin
          if (rq.index < gvf_pkg::MAX_GARCH_LAGS)
            weight_table[gvf_pkg::GARCH_BASE + rq.index] = rq.coef;
        end
        default: ;
      endcase
      return;
    end
    // new series: lags before the start count as zero
    if (rq.first) begin
      foreach (resid_line[i]) resid_line[i] = '0;
      foreach (var_line[i]) var_line[i] = '0;
    end
    // counts beyond the table capacity behave as the capacity
    nb = (m_regressors > gvf_pkg::MAX_REGRESSORS) ? gvf_pkg::MAX_REGRESSORS
                                                  : int'(m_regressors);
    np = (m_arch_lags > gvf_pkg::MAX_ARCH_LAGS) ? gvf_pkg::MAX_ARCH_LAGS
                                                : int'(m_arch_lags);
    nq = (m_garch_lags > gvf_pkg::MAX_GARCH_LAGS) ? gvf_pkg::MAX_GARCH_LAGS
                                                  : int'(m_garch_lags);
    acc = m_const_en ? longint'(m_const_term) : 64'sd0;
    // every product is floored back to q16.16 before it is summed
    for (int i = 0; i < nb; i++) begin
      prod = longint'(weight_table[i]) * longint'($signed(rq.regr[i]));
      acc += prod >>> gvf_pkg::FRAC_W;
    end
    for (int i = 0; i < np; i++) begin
      // squared residual clips at the positive q16.16 limit
      sq = (longint'(resid_line[i]) * longint'(resid_line[i])) >>> gvf_pkg::FRAC_W;
      if (sq > VAR_MAX) sq = VAR_MAX;
      prod = longint'(weight_table[gvf_pkg::ARCH_BASE + i]) * sq;
      acc += prod >>> gvf_pkg::FRAC_W;
    end
    for (int i = 0; i < nq; i++) begin
      prod = longint'(weight_table[gvf_pkg::GARCH_BASE + i]) * longint'(var_line[i]);
      acc += prod >>> gvf_pkg::FRAC_W;
    end
    if (acc > VAR_MAX) acc = VAR_MAX;
    else if (acc < VAR_MIN) acc = VAR_MIN;
    // push this date into both delay lines
    for (int i = gvf_pkg::MAX_ARCH_LAGS - 1; i > 0; i--) resid_line[i] = resid_line[i - 1];
    resid_line[0] = rq.resid;
    for (int i = gvf_pkg::MAX_GARCH_LAGS - 1; i > 0; i--) var_line[i] = var_line[i - 1];
    var_line[0] = acc[gvf_pkg::DATA_W-1:0];
    expected_variances.push_back(acc[gvf_pkg::DATA_W-1:0]);
  endtask

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // mostly back to back, often a short gap, now and then a long one
  function automatic int pick_gap();
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // drives one request, holds it until accepted, then predicts it;
  // valid stays high so a following request can go out back to back
  task automatic send_request(input gvf_request_t rq);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid       <= 1'b1;
    req_type        <= rq.rtype;
    coef_kind       <= rq.kind;
    coef_index      <= rq.index;
    coef_value      <= rq.coef;
    first_of_series <= rq.first;
    residual        <= rq.resid;
    regressor_0     <= rq.regr[0];
    regressor_1     <= rq.regr[1];
    regressor_2     <= rq.regr[2];
    regressor_3     <= rq.regr[3];
    do @(posedge clk); while (req_stall);
    predict_variance_step(rq);
  endtask

  // sample request; the unused write fields carry random bits
  function automatic gvf_request_t sample_request(input logic first,
      input logic [gvf_pkg::DATA_W-1:0] resid, input logic [gvf_pkg::DATA_W-1:0] r0,
      input logic [gvf_pkg::DATA_W-1:0] r1, input logic [gvf_pkg::DATA_W-1:0] r2,
      input logic [gvf_pkg::DATA_W-1:0] r3);
    gvf_request_t rq;
    rq       = '0;
    rq.rtype = gvf_pkg::REQ_SAMPLE;
    rq.kind  = 2'($urandom_range(0, 3));
    rq.index = 3'($urandom_range(0, 7));
    rq.coef  = $urandom();
    rq.first = first;
    rq.resid = resid;
    rq.regr  = {r3, r2, r1, r0};
    return rq;
  endfunction

  // coefficient write; the unused sample fields carry random bits
  function automatic gvf_request_t write_request(input logic [1:0] kind,
      input logic [2:0] index, input logic [gvf_pkg::DATA_W-1:0] value);
    gvf_request_t rq;
    rq       = '0;
    rq.rtype = gvf_pkg::REQ_WRITE;
    rq.kind  = kind;
    rq.index = index;
    rq.coef  = value;
    rq.first = 1'($urandom_range(0, 1));
    rq.resid = $urandom();
    rq.regr  = {$urandom(), $urandom(), $urandom(), $urandom()};
    return rq;
  endfunction

  // q16.16 value within +-span, or any 32-bit pattern one time in eight
  function automatic logic [gvf_pkg::DATA_W-1:0] rand_q16(input int span);
    if ($urandom_range(0, 7) == 0) return $urandom();
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // random write, mostly into a real group, sometimes to the missing group
  function automatic gvf_request_t random_write();
    logic [1:0] kind;
    kind = ($urandom_range(0, 15) == 0) ? KIND_NONE : 2'($urandom_range(0, 2));
    return write_request(kind, 3'($urandom_range(0, 7)), rand_q16(65536));
  endfunction

  function automatic gvf_request_t random_sample(input logic first);
    return sample_request(first, rand_q16(262144), rand_q16(262144), rand_q16(262144),
                          rand_q16(262144), rand_q16(262144));
  endfunction

  // sender holds off until every variance owed has come back
  task automatic wait_for_results();
    req_valid <= 1'b0;
    do @(posedge clk); while (expected_variances.size() != 0);
  endtask

  // block fully idle: nothing owed and any trailing write finished
  task automatic settle();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [gvf_pkg::CFG_IDX_W-1:0] idx,
                                input logic [gvf_pkg::DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    note_register(idx, data);
  endtask

  // writes all five registers while the block is idle
  task automatic apply_settings(input logic en, input logic [gvf_pkg::DATA_W-1:0] term,
      input logic [2:0] nreg, input logic [3:0] narch, input logic [3:0] ngarch);
    settle();
    write_register(gvf_pkg::CFG_CONST_ENABLE, gvf_pkg::DATA_W'(en));
    write_register(gvf_pkg::CFG_CONST_TERM, term);
    write_register(gvf_pkg::CFG_REGRESSOR_COUNT, gvf_pkg::DATA_W'(nreg));
    write_register(gvf_pkg::CFG_ARCH_LAGS, gvf_pkg::DATA_W'(narch));
    write_register(gvf_pkg::CFG_GARCH_LAGS, gvf_pkg::DATA_W'(ngarch));
    cfg_write <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // receiver stalls: often free, short stalls, the odd long one
  always @(posedge clk) begin
    if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else if (steady || $urandom_range(0, 99) < 60) begin
      var_stall <= 1'b0;
    end else begin
      var_stall  <= 1'b1;
      stall_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(0, 2);
    end
  end

  task automatic report_mismatch(input string what, input logic [gvf_pkg::DATA_W-1:0] want,
                                 input logic [gvf_pkg::DATA_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("mismatch %0d at %0t: %s expected %h actual %h",
               mismatch_count, $realtime, what, want, got);
  endtask

  // every accepted variance is matched against the oldest one owed
  always @(posedge clk) begin
    if (!rst && var_valid && !var_stall) begin
      if (expected_variances.size() == 0) begin
        report_mismatch("variance with no request outstanding", 'x, variance);
      end else begin
        want_variance = expected_variances.pop_front();
        if (variance !== want_variance) report_mismatch("variance", want_variance, variance);
      end
    end
  end

  // hang detector: counts cycles in which neither channel moves
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (req_valid && !req_stall) || (var_valid && !var_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("garch_variance_filter_top verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset state: empty table gives zero variance even for extreme inputs
  task automatic test_reset_defaults();
    send_request(sample_request(1'b1, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
    send_request(sample_request(1'b0, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
  endtask

  // first and last slot of each group, plus writes that must be dropped
  task automatic test_coefficient_writes();
    send_request(write_request(gvf_pkg::KIND_BETA, 3'd0, Q_MAX));
    send_request(write_request(gvf_pkg::KIND_BETA, 3'(gvf_pkg::MAX_REGRESSORS - 1), Q_MIN));
    send_request(write_request(gvf_pkg::KIND_ARCH, 3'd0, Q_ONE));
    send_request(write_request(gvf_pkg::KIND_ARCH, 3'(gvf_pkg::MAX_ARCH_LAGS - 1), Q_MAX));
    send_request(write_request(gvf_pkg::KIND_GARCH, 3'd0, Q_MIN));
    send_request(write_request(gvf_pkg::KIND_GARCH, 3'(gvf_pkg::MAX_GARCH_LAGS - 1), Q_HALF));
    // beta index past capacity and the missing group: ignored
    send_request(write_request(gvf_pkg::KIND_BETA, 3'(gvf_pkg::MAX_REGRESSORS), Q_MAX));
    send_request(write_request(KIND_NONE, 3'd0, Q_MAX));
  endtask

  // full counts with extreme constant, regressors and residuals: clip both ways
  task automatic test_saturation();
    apply_settings(1'b1, Q_MAX, 3'(gvf_pkg::MAX_REGRESSORS), 4'(gvf_pkg::MAX_ARCH_LAGS),
                   4'(gvf_pkg::MAX_GARCH_LAGS));
    send_request(sample_request(1'b1, Q_MIN, Q_MAX, Q_ZERO, Q_ZERO, Q_MIN));
    send_request(sample_request(1'b0, Q_MAX, Q_MIN, Q_ZERO, Q_ZERO, Q_MAX));
    send_request(sample_request(1'b0, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO));
    apply_settings(1'b1, Q_MIN, 3'(gvf_pkg::MAX_REGRESSORS), 4'(gvf_pkg::MAX_ARCH_LAGS),
                   4'(gvf_pkg::MAX_GARCH_LAGS));
    send_request(sample_request(1'b0, Q_HALF, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO));
  endtask

  // counts above capacity act as the maximum; zero counts leave the constant
  task automatic test_capacity_limits();
    apply_settings(1'b0, Q_ZERO, 3'd7, 4'd15, 4'd15);
    send_request(sample_request(1'b1, Q_ONE, Q_ONE, Q_HALF, Q_ONE, Q_HALF));
    send_request(sample_request(1'b0, Q_HALF, Q_HALF, Q_ONE, Q_HALF, Q_ONE));
    send_request(sample_request(1'b0, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE));
    apply_settings(1'b1, Q_HALF, 3'd0, 4'd0, 4'd0);
    send_request(sample_request(1'b0, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
    send_request(sample_request(1'b1, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
  endtask

  // register indexes past the list must not disturb the settings
  task automatic test_unused_registers();
    settle();
    for (int k = int'(gvf_pkg::CFG_GARCH_LAGS) + 1; k < (1 << gvf_pkg::CFG_IDX_W); k++)
      write_register(gvf_pkg::CFG_IDX_W'(k), '1);
    cfg_write <= 1'b0;
    send_request(sample_request(1'b0, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE));
  endtask

  // random series under changing settings; most series are well formed,
  // with coefficient updates and stray series restarts mixed in
  task automatic test_random_series();
    int sent, phase, phase_end, series_len, roll;
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      // first phases pin the extremes, later ones draw settings at random
      case (phase)
        0: apply_settings(1'b1, rand_q16(65536), 3'(gvf_pkg::MAX_REGRESSORS),
                          4'(gvf_pkg::MAX_ARCH_LAGS), 4'(gvf_pkg::MAX_GARCH_LAGS));
        1: apply_settings(1'b0, $urandom(), 3'd7, 4'd15, 4'd15);
        2: apply_settings(1'b1, rand_q16(65536), 3'd0, 4'd0, 4'd0);
        default: apply_settings(1'($urandom_range(0, 1)), rand_q16(65536),
                                3'($urandom_range(0, 7)), 4'($urandom_range(0, 10)),
                                4'($urandom_range(0, 10)));
      endcase
      phase_end = sent + PHASE_ITEMS;
      while (sent < phase_end && sent < RANDOM_ITEMS) begin
        steady = ($urandom_range(0, 4) == 0);
        // load some weights, open a series, then run it
        repeat ($urandom_range(0, 6)) begin
          send_request(random_write());
          sent++;
        end
        send_request(random_sample(1'b1));
        sent++;
        series_len = $urandom_range(2, 40);
        for (int k = 1; k < series_len; k++) begin
          roll = $urandom_range(0, 99);
          if (roll == 0) wait_for_results();
          if (roll < 8) send_request(random_write());
          else send_request(random_sample(roll < 11));
          sent++;
        end
      end
      phase++;
    end
    steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    // predicted state after reset
    foreach (resid_line[i]) resid_line[i] = '0;
    foreach (var_line[i]) var_line[i] = '0;
    foreach (weight_table[i]) weight_table[i] = '0;
    m_const_en   = 1'b0;
    m_const_term = '0;
    m_regressors = 3'd0;
    m_arch_lags  = 4'd1;
    m_garch_lags = 4'd1;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_coefficient_writes();
    test_saturation();
    test_capacity_limits();
    test_unused_registers();
    test_random_series();

    // drain, then give any stray result time to show up
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("garch_variance_filter_top verification clean");
    else
      $display("garch_variance_filter_top verification failed");
    $finish;
  end

endmodule
